FILE: rtl/core/piecewise_cubic_bezier_eval_macros.svh
// ---------------------------------------------------------------------------
// Piecewise cubic Bezier evaluator - assertion macros
// Shared helpers for the concurrent checks in the core modules.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_CUBIC_BEZIER_EVAL_MACROS_SVH
`define PIECEWISE_CUBIC_BEZIER_EVAL_MACROS_SVH

// same-cycle implication, disabled in reset
`define PCBE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define PCBE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/cpb_pkg.sv
// ---------------------------------------------------------------------------
// cpb_pkg
// Types and fixed constants of the piecewise cubic Bezier evaluator.
// ---------------------------------------------------------------------------
package cpb_pkg;

  localparam int COORD_W     = 16;
  localparam int FRAC_W      = 16;
  localparam int INDEX_W     = 10;
  localparam int STATION_W   = 10;
  localparam int COUNT_W     = 11;
  localparam int SEGS_W      = COUNT_W - 2;
  localparam int SEG_W       = 10;
  localparam int SHARE_W     = 10;
  localparam int NUM_W       = SHARE_W + FRAC_W;
  localparam int RECIP_SHIFT = NUM_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int DIV_CNT_W   = 5;
  localparam int STATIONS    = 1000;

  // floor(2^29 / 1000), segment quotient estimate
  localparam int SEG_RECIP_SHIFT = 29;
  localparam int SEG_RECIP_W     = 20;
  localparam logic [SEG_RECIP_W-1:0] SEG_RECIP = SEG_RECIP_W'((2**SEG_RECIP_SHIFT) / STATIONS);

  // register reset: four points, one segment
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);
  localparam logic [SHARE_W-1:0] SHARE_RESET = SHARE_W'(STATIONS);
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'((2**RECIP_SHIFT) / STATIONS);

  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_W       = 3;
  localparam int QCNT_W       = 4;
  localparam int FRONT_STAGES = 6;

  localparam int A_W   = 21;
  localparam int ACC_W = 40;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_LOAD_SHARE,
    CFG_SHARE,
    CFG_LOAD_RECIP,
    CFG_RECIP
  } cfg_state_t;

  // word moved through the queue
  typedef struct packed {
    logic                      is_eval;
    logic [INDEX_W-1:0]        addr;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [FRAC_W-1:0]         frac;
  } item_t;

endpackage

FILE: rtl/core/cpb_front.sv
// ---------------------------------------------------------------------------
// cpb_front
// Takes words and config, finds segment and local fraction of a station.
// ---------------------------------------------------------------------------
`include "piecewise_cubic_bezier_eval_macros.svh"

module cpb_front #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode,
  input  logic [cpb_pkg::INDEX_W-1:0]        point_index,
  input  logic signed [cpb_pkg::COORD_W-1:0] coord_x,
  input  logic signed [cpb_pkg::COORD_W-1:0] coord_y,
  input  logic [cpb_pkg::STATION_W-1:0]      station,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cpb_pkg::COUNT_W-1:0]        cfg_data,
  input  logic [cpb_pkg::QCNT_W-1:0]         q_count,
  output logic                               push,
  output cpb_pkg::item_t                     push_word
);
  import cpb_pkg::*;

  localparam int CMP_W = 13;
  localparam logic [CMP_W-1:0] MAXP = CMP_W'(MAX_POINTS);
  localparam int P_W = STATION_W + SEGS_W;
  localparam int T_W = STATION_W + RECIP_W;
  localparam int ST_W = P_W + SEG_RECIP_W;
  localparam int QP_W = STATION_W + SHARE_W;
  localparam int FT_W = NUM_W + RECIP_W;

  // config register and derived values
  logic [COUNT_W-1:0] point_count;
  logic [SHARE_W-1:0] share;
  logic [RECIP_W-1:0] recip;
  logic [CMP_W-1:0]   count_clamp;
  logic [SEGS_W-1:0]  segs;

  always_comb begin
    count_clamp = (CMP_W'(point_count) > MAXP) ? MAXP : CMP_W'(point_count);
    segs = SEGS_W'(count_clamp >> 2);
    if (segs == '0) begin
      segs = SEGS_W'(1);
    end
  end

  // divider sequencer: share = 1000/segs, then recip = 2^26/share
  cfg_state_t           cstate, cstate_next;
  logic [SHARE_W-1:0]   div_rem;
  logic [RECIP_W-1:0]   div_quo;
  logic [SHARE_W-1:0]   div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 cfg_wr;
  logic                 div_last;
  logic                 div_load, div_step, load_recip_sel, share_done, recip_done;
  logic [SHARE_W:0]     div_sh;
  logic                 div_ge;
  logic [SHARE_W-1:0]   div_rem_n;
  logic [RECIP_W-1:0]   div_quo_n;

  assign cfg_wr   = cfg_valid && cfg_ready;
  assign div_last = (div_cnt == DIV_CNT_W'(RECIP_W - 1));

  always_comb begin
    cstate_next = cstate;
    unique case (cstate)
      CFG_IDLE:       if (cfg_wr) cstate_next = CFG_LOAD_SHARE;
      CFG_LOAD_SHARE: cstate_next = CFG_SHARE;
      CFG_SHARE:      if (div_last) cstate_next = CFG_LOAD_RECIP;
      CFG_LOAD_RECIP: cstate_next = CFG_RECIP;
      CFG_RECIP:      if (div_last) cstate_next = CFG_IDLE;
      default:        cstate_next = CFG_IDLE;
    endcase
  end

  always_comb begin
    div_load       = 1'b0;
    div_step       = 1'b0;
    load_recip_sel = 1'b0;
    share_done     = 1'b0;
    recip_done     = 1'b0;
    cfg_ready      = 1'b0;
    unique case (cstate)
      CFG_IDLE:       cfg_ready = 1'b1;
      CFG_LOAD_SHARE: div_load = 1'b1;
      CFG_SHARE: begin
        div_step   = 1'b1;
        share_done = div_last;
      end
      CFG_LOAD_RECIP: begin
        div_load       = 1'b1;
        load_recip_sel = 1'b1;
      end
      CFG_RECIP: begin
        div_step   = 1'b1;
        recip_done = div_last;
      end
      default: cfg_ready = 1'b0;
    endcase
  end

  // one restoring step per cycle
  always_comb begin
    div_sh    = {div_rem, div_quo[RECIP_W-1]};
    div_ge    = (div_sh >= {1'b0, div_den});
    div_rem_n = div_ge ? SHARE_W'(div_sh - {1'b0, div_den}) : SHARE_W'(div_sh);
    div_quo_n = {div_quo[RECIP_W-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate      <= CFG_IDLE;
      point_count <= COUNT_RESET;
      share       <= SHARE_RESET;
      recip       <= RECIP_RESET;
    end else begin
      cstate <= cstate_next;
      if (cfg_wr) begin
        point_count <= cfg_data;
      end
      if (share_done) begin
        share <= div_quo_n[SHARE_W-1:0];
      end
      if (recip_done) begin
        recip <= div_quo_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      div_rem <= '0;
      div_cnt <= '0;
      if (load_recip_sel) begin
        div_quo <= RECIP_W'(1) << RECIP_SHIFT;
        div_den <= share;
      end else begin
        div_quo <= RECIP_W'(STATIONS);
        div_den <= SHARE_W'(segs);
      end
    end else if (div_step) begin
      div_rem <= div_rem_n;
      div_quo <= div_quo_n;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // admission: room in the queue for everything in flight
  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic [QCNT_W:0] inflight;
  logic            accept;

  assign inflight = (QCNT_W+1)'(s1_v) + (QCNT_W+1)'(s2_v) + (QCNT_W+1)'(s3_v)
                  + (QCNT_W+1)'(s4_v) + (QCNT_W+1)'(s5_v) + (QCNT_W+1)'(s6_v);
  assign busy   = (cstate != CFG_IDLE)
               || ((QCNT_W+1)'(q_count) + inflight >= (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept = start && !busy;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      {s1_v, s2_v, s3_v, s4_v, s5_v, s6_v} <= '0;
    end else begin
      {s1_v, s2_v, s3_v, s4_v, s5_v, s6_v} <= {accept, s1_v, s2_v, s3_v, s4_v, s5_v};
    end
  end

  // stage 1: capture
  item_t                s1_item, s2_item, s3_item, s4_item, s5_item, s6_item;
  logic [STATION_W-1:0] s1_station, s2_station, s3_station;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.is_eval <= (mode == MODE_EVAL);
      s1_item.addr    <= point_index;
      s1_item.x       <= coord_x;
      s1_item.y       <= coord_y;
      s1_item.frac    <= '0;
      s1_station      <= station;
    end
  end

  // stage 2: station*segs and station quotient estimate
  logic [P_W-1:0]       c1_p, s2_p, s3_p;
  logic [T_W-1:0]       c1_t;
  logic [STATION_W-1:0] s2_qs;

  assign c1_p = P_W'(s1_station) * P_W'(segs);
  assign c1_t = T_W'(s1_station) * T_W'(recip);

  always_ff @(posedge clk) begin
    s2_item    <= s1_item;
    s2_station <= s1_station;
    s2_p       <= c1_p;
    s2_qs      <= c1_t[RECIP_SHIFT +: STATION_W];
  end

  // stage 3: segment estimate, quotient times share
  logic [ST_W-1:0]      c2_segt;
  logic [QP_W-1:0]      c2_qp;
  logic [SEG_W-1:0]     s3_seg_est;
  logic [STATION_W-1:0] s3_qp;

  assign c2_segt = ST_W'(s2_p) * ST_W'(SEG_RECIP);
  assign c2_qp   = QP_W'(s2_qs) * QP_W'(share);

  always_ff @(posedge clk) begin
    s3_item    <= s2_item;
    s3_station <= s2_station;
    s3_p       <= s2_p;
    s3_seg_est <= c2_segt[SEG_RECIP_SHIFT +: SEG_W];
    s3_qp      <= c2_qp[STATION_W-1:0];
  end

  // stage 4: correct segment and remainder
  logic [P_W-1:0]       seg_prod, seg_r;
  logic [SEG_W-1:0]     seg_fix, seg_sat;
  logic [STATION_W-1:0] rem0, rem;
  logic [SHARE_W-1:0]   s4_rem;
  item_t                c3_item;

  always_comb begin
    seg_prod = P_W'(s3_seg_est) * P_W'(STATIONS);
    seg_r    = s3_p - seg_prod;
    seg_fix  = s3_seg_est + SEG_W'(seg_r >= P_W'(STATIONS));
    seg_sat  = (seg_fix >= SEG_W'(segs)) ? SEG_W'(segs - SEGS_W'(1)) : seg_fix;
    rem0     = s3_station - s3_qp;
    rem      = (rem0 >= STATION_W'(share)) ? rem0 - STATION_W'(share) : rem0;
  end

  // evaluations carry the segment index in the address field
  always_comb begin
    c3_item = s3_item;
    if (s3_item.is_eval) begin
      c3_item.addr = INDEX_W'(seg_sat);
    end
  end

  always_ff @(posedge clk) begin
    s4_item <= c3_item;
    s4_rem  <= SHARE_W'(rem);
  end

  // stage 5: fraction estimate rem*2^16*recip
  logic [NUM_W-1:0]  c4_num, s5_num;
  logic [FT_W-1:0]   c4_ft;
  logic [FRAC_W-1:0] s5_fe, s6_fe;

  assign c4_num = {s4_rem, FRAC_W'(0)};
  assign c4_ft  = FT_W'(c4_num) * FT_W'(recip);

  always_ff @(posedge clk) begin
    s5_item <= s4_item;
    s5_num  <= c4_num;
    s5_fe   <= c4_ft[RECIP_SHIFT +: FRAC_W];
  end

  // stage 6: fraction residue
  logic [NUM_W-1:0] c5_fp, s6_r;

  assign c5_fp = NUM_W'(s5_fe) * NUM_W'(share);

  always_ff @(posedge clk) begin
    s6_item <= s5_item;
    s6_fe   <= s5_fe;
    s6_r    <= s5_num - c5_fp;
  end

  // fraction is off by at most one
  always_comb begin
    push_word      = s6_item;
    push_word.frac = s6_fe + FRAC_W'(s6_r >= NUM_W'(share));
  end
  assign push = s6_v;

  `PCBE_ASSERT_NXT(a_cfg_starts_div, clk, rst, cfg_wr, cstate == CFG_LOAD_SHARE)
  `PCBE_ASSERT_IMP(a_no_accept_in_div, clk, rst, accept, cstate == CFG_IDLE)
  `PCBE_ASSERT_IMP(a_seg_in_range, clk, rst, push && push_word.is_eval,
    push_word.addr < INDEX_W'(segs))

endmodule

FILE: rtl/core/cpb_queue.sv
// ---------------------------------------------------------------------------
// cpb_queue
// Short FIFO between front and back; the back drains one word a cycle.
// ---------------------------------------------------------------------------
`include "piecewise_cubic_bezier_eval_macros.svh"

module cpb_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  cpb_pkg::item_t             push_word,
  output logic                       pop,
  output cpb_pkg::item_t             pop_word,
  output logic [cpb_pkg::QCNT_W-1:0] count
);
  import cpb_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign pop      = (count != '0);
  assign pop_word = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  `PCBE_ASSERT_IMP(a_no_overflow, clk, rst, push, count < QCNT_W'(QUEUE_DEPTH) || pop)
  `PCBE_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))
  `PCBE_ASSERT_NXT(a_drain, clk, rst, pop && !push, count == $past(count) - QCNT_W'(1))

endmodule

FILE: rtl/core/cpb_back.sv
// ---------------------------------------------------------------------------
// cpb_back
// Point store in four banks and the Horner pipeline for x and y.
// ---------------------------------------------------------------------------
module cpb_back #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pop,
  input  cpb_pkg::item_t                     pop_word,
  output logic                               result_valid,
  output logic signed [cpb_pkg::COORD_W-1:0] curve_x,
  output logic signed [cpb_pkg::COORD_W-1:0] curve_y
);
  import cpb_pkg::*;

  localparam int BANK_DEPTH = (MAX_POINTS + 3) / 4;
  localparam int ROW_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CMP_W = 13;
  localparam int M1_W  = A_W + FRAC_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2**(COORD_W-1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  // signed Q.16 times unsigned Q0.16, truncated toward zero
  function automatic logic signed [ACC_W-1:0] fx_mul(input logic signed [ACC_W-1:0] v,
                                                     input logic [FRAC_W-1:0] f);
    logic [ACC_W-1:0]        mag;
    logic [ACC_W+FRAC_W-1:0] prod;
    logic [ACC_W-1:0]        sh;
    mag    = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    prod   = (ACC_W+FRAC_W)'(mag) * (ACC_W+FRAC_W)'(f);
    sh     = prod[FRAC_W +: ACC_W];
    fx_mul = v[ACC_W-1] ? -$signed(sh) : $signed(sh);
  endfunction

  // bank select by low index bits; a segment reads one row of every bank
  logic             wr_en;
  logic [1:0]       wr_bank;
  logic [ROW_W-1:0] wr_row, rd_row;

  assign wr_en   = pop && !pop_word.is_eval
                && (CMP_W'(pop_word.addr) < CMP_W'(MAX_POINTS));
  assign wr_bank = pop_word.addr[1:0];
  assign wr_row  = ROW_W'(pop_word.addr[INDEX_W-1:2]);
  assign rd_row  = ROW_W'(pop_word.addr);

  logic signed [COORD_W-1:0] b1_p [2][4];
  logic                      b1_v;
  logic [FRAC_W-1:0]         b1_frac;

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [COORD_W-1:0] mem_x [BANK_DEPTH];
    logic [COORD_W-1:0] mem_y [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(k))) begin
        mem_x[wr_row] <= pop_word.x;
        mem_y[wr_row] <= pop_word.y;
      end
      b1_p[0][k] <= mem_x[rd_row];
      b1_p[1][k] <= mem_y[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    b1_frac <= pop_word.frac;
  end

  // valid chain
  logic b2_v, b3_v, b4_v, b5_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      {b1_v, b2_v, b3_v, b4_v, b5_v, result_valid} <= '0;
    end else begin
      {b1_v, b2_v, b3_v, b4_v, b5_v, result_valid} <=
        {pop && pop_word.is_eval, b1_v, b2_v, b3_v, b4_v, b5_v};
    end
  end

  logic [FRAC_W-1:0]       b2_frac, b3_frac, b4_frac;
  logic signed [COORD_W-1:0] res [2];

  always_ff @(posedge clk) begin
    b2_frac <= b1_frac;
    b3_frac <= b2_frac;
    b4_frac <= b3_frac;
  end

  for (genvar c = 0; c < 2; c++) begin : g_coord
    logic signed [A_W-1:0]   e0, e1, e2, e3, cc, bb, aa;
    logic signed [A_W-1:0]   b2_a, b2_b, b2_c, b3_c;
    logic signed [COORD_W-1:0] b2_p0, b3_p0, b4_p0;
    logic signed [M1_W-1:0]  m1;
    logic signed [ACC_W-1:0] acc1, acc2, acc3;
    logic signed [ACC_W-1:0] b3_acc, b4_acc, b5_acc;
    logic [ACC_W-1:0]        fin_mag;
    logic signed [ACC_W-1:0] fin;

    // power-basis coefficients
    always_comb begin
      e0 = A_W'(b1_p[c][0]);
      e1 = A_W'(b1_p[c][1]);
      e2 = A_W'(b1_p[c][2]);
      e3 = A_W'(b1_p[c][3]);
      cc = A_W'(3) * (e1 - e0);
      bb = A_W'(3) * (e2 - e1) - cc;
      aa = e3 - e0 - cc - bb;
    end

    always_ff @(posedge clk) begin
      b2_a  <= aa;
      b2_b  <= bb;
      b2_c  <= cc;
      b2_p0 <= b1_p[c][0];
    end

    // Horner: a*s + b is exact
    assign m1   = b2_a * $signed({1'b0, b2_frac});
    assign acc1 = ACC_W'(m1) + (ACC_W'(b2_b) <<< FRAC_W);

    always_ff @(posedge clk) begin
      b3_acc <= acc1;
      b3_c   <= b2_c;
      b3_p0  <= b2_p0;
    end

    assign acc2 = fx_mul(b3_acc, b3_frac) + (ACC_W'(b3_c) <<< FRAC_W);

    always_ff @(posedge clk) begin
      b4_acc <= acc2;
      b4_p0  <= b3_p0;
    end

    assign acc3 = fx_mul(b4_acc, b4_frac) + (ACC_W'(b4_p0) <<< FRAC_W);

    always_ff @(posedge clk) begin
      b5_acc <= acc3;
    end

    // truncate toward zero, saturate
    always_comb begin
      fin_mag = b5_acc[ACC_W-1] ? ACC_W'(-b5_acc) : ACC_W'(b5_acc);
      fin_mag = fin_mag >> FRAC_W;
      fin     = b5_acc[ACC_W-1] ? -$signed(fin_mag) : $signed(fin_mag);
      if (fin > SAT_MAX) begin
        res[c] = COORD_W'(SAT_MAX);
      end else if (fin < SAT_MIN) begin
        res[c] = COORD_W'(SAT_MIN);
      end else begin
        res[c] = COORD_W'(fin);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    curve_x <= res[0];
    curve_y <= res[1];
  end

endmodule

FILE: rtl/core/piecewise_cubic_bezier_eval.sv
// ---------------------------------------------------------------------------
// piecewise_cubic_bezier_eval
// Top level: front decode, word queue, point store and cubic evaluator.
// ---------------------------------------------------------------------------
// Usage:
//  - A word is taken at a clock edge with start high and busy low. mode
//    selects a point load (point_index, coord_x, coord_y) or an evaluation
//    at station (0..999 along the whole curve).
//  - Loads give no result. Each evaluation gives one result: result_valid
//    is high for one cycle with curve_x/curve_y, after decode, queue and
//    back end. The receiver cannot stall; results come in order.
//  - Throughput is one word per cycle while busy is low, loads and evaluations
//    mixed freely. Outside a cfg divide, busy rises only when the six-stage
//    decode plus the 8-word queue could overflow, which a draining back end never lets happen.
//  - point_count is written on the cfg channel (cfg_valid/cfg_ready). Each
//    write starts the shared bit-serial divider, with cfg_ready
//    and start-acceptance held off while segment share and its reciprocal
//    are formed.
//  - Reset: point_count = 4 with its derived values preloaded, pipeline
//    and queue empty. The point store is not cleared; read points only
//    after loading them.
// ---------------------------------------------------------------------------
module piecewise_cubic_bezier_eval #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode,
  input  logic [cpb_pkg::INDEX_W-1:0]        point_index,
  input  logic signed [cpb_pkg::COORD_W-1:0] coord_x,
  input  logic signed [cpb_pkg::COORD_W-1:0] coord_y,
  input  logic [cpb_pkg::STATION_W-1:0]      station,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cpb_pkg::COUNT_W-1:0]        cfg_data,
  output logic                               result_valid,
  output logic signed [cpb_pkg::COORD_W-1:0] curve_x,
  output logic signed [cpb_pkg::COORD_W-1:0] curve_y
);
  import cpb_pkg::*;

  logic              push, pop;
  item_t             push_word, pop_word;
  logic [QCNT_W-1:0] q_count;

  cpb_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .point_index (point_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .station     (station),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_count     (q_count),
    .push        (push),
    .push_word   (push_word)
  );

  cpb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .count     (q_count)
  );

  cpb_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop          (pop),
    .pop_word     (pop_word),
    .result_valid (result_valid),
    .curve_x      (curve_x),
    .curve_y      (curve_y)
  );

endmodule
